@@ rtl/core/tked_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tked_pkg
// Shared key codes, byte values and types for the terminal key decoder.
// ----------------------------------------------------------------------------
package tked_pkg;

  localparam int unsigned KEY_W = 5;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TICKS_W = 16;

  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd40;

  // key event codes
  localparam logic [KEY_W-1:0] K_UNKNOWN = 5'd0;
  localparam logic [KEY_W-1:0] K_CHAR    = 5'd1;
  localparam logic [KEY_W-1:0] K_TAB     = 5'd2;
  localparam logic [KEY_W-1:0] K_ENTER   = 5'd3;
  localparam logic [KEY_W-1:0] K_CTRLC   = 5'd4;
  localparam logic [KEY_W-1:0] K_CTRLD   = 5'd5;
  localparam logic [KEY_W-1:0] K_WBKSP   = 5'd6;
  localparam logic [KEY_W-1:0] K_BKSP    = 5'd7;
  localparam logic [KEY_W-1:0] K_HOME    = 5'd8;
  localparam logic [KEY_W-1:0] K_END     = 5'd9;
  localparam logic [KEY_W-1:0] K_DEL     = 5'd10;
  localparam logic [KEY_W-1:0] K_LEFT    = 5'd11;
  localparam logic [KEY_W-1:0] K_RIGHT   = 5'd12;
  localparam logic [KEY_W-1:0] K_UP      = 5'd13;
  localparam logic [KEY_W-1:0] K_DOWN    = 5'd14;
  localparam logic [KEY_W-1:0] K_WLEFT   = 5'd15;
  localparam logic [KEY_W-1:0] K_WRIGHT  = 5'd16;

  // action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // byte values
  localparam logic [BYTE_W-1:0] B_CTRL_A = 8'h01;
  localparam logic [BYTE_W-1:0] B_CTRL_C = 8'h03;
  localparam logic [BYTE_W-1:0] B_CTRL_D = 8'h04;
  localparam logic [BYTE_W-1:0] B_CTRL_E = 8'h05;
  localparam logic [BYTE_W-1:0] B_BS     = 8'h08;
  localparam logic [BYTE_W-1:0] B_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] B_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] B_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] B_CTRL_W = 8'h17;
  localparam logic [BYTE_W-1:0] B_ESC    = 8'h1B;
  localparam logic [BYTE_W-1:0] B_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] B_TILDE  = 8'h7E;
  localparam logic [BYTE_W-1:0] B_DEL    = 8'h7F;
  localparam logic [BYTE_W-1:0] B_0      = 8'h30;
  localparam logic [BYTE_W-1:0] B_1      = 8'h31;
  localparam logic [BYTE_W-1:0] B_3      = 8'h33;
  localparam logic [BYTE_W-1:0] B_4      = 8'h34;
  localparam logic [BYTE_W-1:0] B_5      = 8'h35;
  localparam logic [BYTE_W-1:0] B_7      = 8'h37;
  localparam logic [BYTE_W-1:0] B_8      = 8'h38;
  localparam logic [BYTE_W-1:0] B_9      = 8'h39;
  localparam logic [BYTE_W-1:0] B_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] B_UA     = 8'h41;
  localparam logic [BYTE_W-1:0] B_UB     = 8'h42;
  localparam logic [BYTE_W-1:0] B_UC     = 8'h43;
  localparam logic [BYTE_W-1:0] B_UD     = 8'h44;
  localparam logic [BYTE_W-1:0] B_UF     = 8'h46;
  localparam logic [BYTE_W-1:0] B_UH     = 8'h48;
  localparam logic [BYTE_W-1:0] B_UO     = 8'h4F;
  localparam logic [BYTE_W-1:0] B_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] B_LB     = 8'h62;
  localparam logic [BYTE_W-1:0] B_LF_F   = 8'h66;

  // one input beat as held in the input register
  typedef struct packed {
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  // handshake controls from the top level to the decoder
  typedef struct packed {
    logic step;
    logic pop;
  } step_ctl_t;

  // SS3 / plain CSI letter finals
  function automatic logic [KEY_W-1:0] letter_key(input logic [BYTE_W-1:0] b);
    logic [KEY_W-1:0] k;
    case (b)
      B_UA:    k = K_UP;
      B_UB:    k = K_DOWN;
      B_UC:    k = K_RIGHT;
      B_UD:    k = K_LEFT;
      B_UH:    k = K_HOME;
      B_UF:    k = K_END;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/terminal_key_escape_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// Turns raw terminal bytes and timer ticks into key events.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with action and rx_byte. Each beat is a
// received byte (action 0) or one timer tick (action 1).
// Output channel: out_valid / out_stall with key and char_code. A beat gives
// zero or one key event; escape prefixes and ticks normally give none.
// Each input beat is held in the input register, then passes through the
// decode into the result register.
// Throughput is one beat per cycle while out_stall is low.
// timeout_ticks is written through cfg_we / cfg_wdata; it resets to 40.
// Reset puts the decoder in idle with no pending sequence and empty registers.
// While out_stall holds a result, one more beat can wait in the input
// register; after that in_stall is raised.
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [tked_pkg::TICKS_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         action,
  input  wire logic [tked_pkg::BYTE_W-1:0]  rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [tked_pkg::KEY_W-1:0]        key,
  output logic [tked_pkg::BYTE_W-1:0]       char_code
);
  import tked_pkg::*;

  logic [TICKS_W-1:0] timeout_ticks;
  logic               s1_valid;
  item_t              s1_item;
  step_ctl_t          ctl;
  logic               out_free;
  logic               in_take;

  assign out_free = !out_valid || !out_stall;
  assign ctl.step = s1_valid && out_free;
  assign ctl.pop  = out_valid && !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (ctl.step) begin
        s1_valid <= 1'b0;
      end
    end
    if (in_take) begin
      s1_item.action  <= action;
      s1_item.rx_byte <= rx_byte;
    end
  end

  tked_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .item          (s1_item),
    .timeout_ticks (timeout_ticks),
    .out_valid     (out_valid),
    .key           (key),
    .char_code     (char_code)
  );

  // input only backs up behind a held result
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // char_code is only carried with a character key
  a_char_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && key != K_CHAR) |-> (char_code == '0))
    else $error("char_code set on a non-character key");

  // a held item is processed as soon as the output frees up
  a_step_drain : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid && !in_take) |=> !s1_valid)
    else $error("input register not drained");

endmodule
`default_nettype wire

@@ rtl/core/tked_fsm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tked_fsm
// Escape sequence state machine with the result register.
// ----------------------------------------------------------------------------
module tked_fsm (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire tked_pkg::step_ctl_t          ctl,
  input  wire tked_pkg::item_t              item,
  input  wire logic [tked_pkg::TICKS_W-1:0] timeout_ticks,
  output logic                              out_valid,
  output logic [tked_pkg::KEY_W-1:0]        key,
  output logic [tked_pkg::BYTE_W-1:0]       char_code
);
  import tked_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_CSI,
    PH_PARAM,
    PH_SS3
  } phase_t;

  typedef enum logic [3:0] {
    PC_OTHER,
    PC_1,
    PC_3,
    PC_4,
    PC_5,
    PC_7,
    PC_8,
    PC_1S,
    PC_13,
    PC_15
  } pclass_t;

  phase_t             phase, phase_next;
  pclass_t            param_class, class_next;
  logic [TICKS_W-1:0] silence_count, count_next;
  logic [TICKS_W-1:0] count_inc;
  logic               emit;
  logic [KEY_W-1:0]   key_next;
  logic [BYTE_W-1:0]  char_next;
  logic               is_digit;
  logic               word_mod;
  logic [BYTE_W-1:0]  b;

  assign b         = item.rx_byte;
  assign count_inc = silence_count + TICKS_W'(1);
  assign is_digit  = (b >= B_0) && (b <= B_9);
  assign word_mod  = (param_class == PC_15) || (param_class == PC_13) ||
                     (param_class == PC_5) || (param_class == PC_3);

  always_comb begin
    phase_next = phase;
    class_next = param_class;
    count_next = silence_count;
    emit       = 1'b0;
    key_next   = K_UNKNOWN;
    char_next  = '0;
    if (item.action == ACT_TICK) begin
      if (phase != PH_IDLE) begin
        count_next = count_inc;
        // zero timeout behaves like one
        if (count_inc >= timeout_ticks) begin
          emit = 1'b1;
        end
      end
    end else begin
      count_next = '0;
      unique case (phase)
        PH_IDLE: begin
          emit = 1'b1;
          case (b)
            B_TAB:          key_next = K_TAB;
            B_CR, B_LF:     key_next = K_ENTER;
            B_CTRL_C:       key_next = K_CTRLC;
            B_CTRL_D:       key_next = K_CTRLD;
            B_CTRL_W:       key_next = K_WBKSP;
            B_BS, B_DEL:    key_next = K_BKSP;
            B_CTRL_A:       key_next = K_HOME;
            B_CTRL_E:       key_next = K_END;
            B_ESC: begin
              emit       = 1'b0;
              phase_next = PH_ESC;
            end
            default: begin
              if (b >= B_SPACE && b <= B_TILDE) begin
                key_next  = K_CHAR;
                char_next = b;
              end
            end
          endcase
        end
        PH_ESC: begin
          case (b)
            B_ESC:       ;  // restart, stay in esc
            B_LBRACK:    phase_next = PH_CSI;
            B_UO:        phase_next = PH_SS3;
            B_LB, B_UB: begin
              emit     = 1'b1;
              key_next = K_WLEFT;
            end
            B_LF_F, B_UF: begin
              emit     = 1'b1;
              key_next = K_WRIGHT;
            end
            B_DEL, B_BS: begin
              emit     = 1'b1;
              key_next = K_WBKSP;
            end
            default:     emit = 1'b1;
          endcase
        end
        PH_CSI: begin
          if (is_digit) begin
            phase_next = PH_PARAM;
            case (b)
              B_1:     class_next = PC_1;
              B_3:     class_next = PC_3;
              B_4:     class_next = PC_4;
              B_5:     class_next = PC_5;
              B_7:     class_next = PC_7;
              B_8:     class_next = PC_8;
              default: class_next = PC_OTHER;
            endcase
          end else begin
            emit     = 1'b1;
            key_next = letter_key(b);
          end
        end
        PH_PARAM: begin
          if (is_digit || b == B_SEMI) begin
            if (param_class == PC_1 && b == B_SEMI) begin
              class_next = PC_1S;
            end else if (param_class == PC_1S && b == B_3) begin
              class_next = PC_13;
            end else if (param_class == PC_1S && b == B_5) begin
              class_next = PC_15;
            end else begin
              class_next = PC_OTHER;
            end
          end else begin
            emit = 1'b1;
            if (b == B_TILDE) begin
              if (param_class == PC_1 || param_class == PC_7) begin
                key_next = K_HOME;
              end else if (param_class == PC_3) begin
                key_next = K_DEL;
              end else if (param_class == PC_4 || param_class == PC_8) begin
                key_next = K_END;
              end
            end else if (b == B_UD) begin
              key_next = word_mod ? K_WLEFT : K_LEFT;
            end else if (b == B_UC) begin
              key_next = word_mod ? K_WRIGHT : K_RIGHT;
            end else begin
              key_next = letter_key(b);
            end
          end
        end
        PH_SS3: begin
          emit     = 1'b1;
          key_next = letter_key(b);
        end
        default: emit = 1'b1;
      endcase
    end
    if (emit) begin
      phase_next = PH_IDLE;
      class_next = PC_OTHER;
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      param_class   <= PC_OTHER;
      silence_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (ctl.step) begin
        phase         <= phase_next;
        param_class   <= class_next;
        silence_count <= count_next;
      end
      if (ctl.step && emit) begin
        out_valid <= 1'b1;
      end else if (ctl.pop) begin
        out_valid <= 1'b0;
      end
    end
    if (ctl.step && emit) begin
      key       <= key_next;
      char_code <= char_next;
    end
  end

endmodule
`default_nettype wire
